/* rtl/chacha20_stream_xor_assert.svh */
// assertion helpers for the chacha20 stream block
`ifndef CHACHA20_STREAM_XOR_ASSERT_SVH
`define CHACHA20_STREAM_XOR_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CC20_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define CC20_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/cc20_pkg.sv */
package cc20_pkg;

    localparam int CC20_DOUBLE_ROUNDS = 10;
    localparam int CC20_WORDS         = 16;
    localparam int CC20_BLOCK_BYTES   = 64;
    localparam int CC20_POS_W         = 7;

    typedef logic [CC20_WORDS-1:0][31:0] t_words;

    // "expand 32-byte k"
    localparam logic [31:0] CC20_SIGMA0 = 32'h61707865;
    localparam logic [31:0] CC20_SIGMA1 = 32'h3320646e;
    localparam logic [31:0] CC20_SIGMA2 = 32'h79622d32;
    localparam logic [31:0] CC20_SIGMA3 = 32'h6b206574;

    typedef enum logic [2:0] {
        CFG_KEY0      = 3'd0,
        CFG_KEY1      = 3'd1,
        CFG_KEY2      = 3'd2,
        CFG_KEY3      = 3'd3,
        CFG_NONCE_LO  = 3'd4,
        CFG_NONCE_HI  = 3'd5,
        CFG_START_CTR = 3'd6
    } t_cfg_idx;

endpackage

/* rtl/chacha20_stream_xor.sv */
// chacha20 keystream xor on a byte stream
// s_axis carries one plaintext or ciphertext byte per word with tlast as the
// message mark; m_axis returns the byte xored with the next keystream byte and
// the same tlast. the cfg channel writes key, nonce and start counter by index
// and is always ready; any write to a listed index restarts the stream.
// a byte accepted while keystream is on hand appears in the output register
// at the next edge. the byte that opens a new 64-byte block is parked while
// cc20_core makes the block with its single half-quarter-round unit; no new
// byte is accepted meanwhile, and the parked byte is xored into the output
// register once the core is done. feed-forward is added as each byte is read.
// reset: key, nonce and counter are zero and the keystream is empty, so the
// first byte starts block zero. the output is a single word register: while
// it holds a word the receiver has not taken, no new input is accepted.
// tlast does not reset the keystream position; it carries into the next message.
module chacha20_stream_xor
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = CC20_DOUBLE_ROUNDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // out_last
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

`include "chacha20_stream_xor_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_GEN  = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [63:0]           r_key0, n_key0, r_key1, n_key1;
    logic [63:0]           r_key2, n_key2, r_key3, n_key3;
    logic [63:0]           r_nonce_lo, n_nonce_lo;
    logic [31:0]           r_nonce_hi, n_nonce_hi;
    logic [63:0]           r_start, n_start;
    logic [63:0]           r_ctr, n_ctr;     // {counter word 13, counter word 12}
    logic [63:0]           r_blk, n_blk;     // counter of the block on hand
    logic [CC20_POS_W-1:0] r_pos, n_pos;
    logic [7:0]            r_hold_data, n_hold_data;
    logic                  r_hold_last, n_hold_last;
    logic [7:0]            r_mdata, n_mdata;
    logic                  r_mlast, n_mlast;
    logic                  r_mvalid, n_mvalid;

    logic        acc_in;
    logic        acc_cfg;
    logic        cfg_hit;
    logic        core_start;
    logic        core_busy;
    t_words      core_words;
    t_words      core_init;
    t_words      ff_init;
    logic [3:0]  ks_idx;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    function automatic t_words make_init(logic [63:0] k0, logic [63:0] k1,
                                         logic [63:0] k2, logic [63:0] k3,
                                         logic [63:0] nlo, logic [31:0] nhi,
                                         logic [63:0] ctr);
        t_words o;
        o[0]  = CC20_SIGMA0;
        o[1]  = CC20_SIGMA1;
        o[2]  = CC20_SIGMA2;
        o[3]  = CC20_SIGMA3;
        o[4]  = k0[31:0];
        o[5]  = k0[63:32];
        o[6]  = k1[31:0];
        o[7]  = k1[63:32];
        o[8]  = k2[31:0];
        o[9]  = k2[63:32];
        o[10] = k3[31:0];
        o[11] = k3[63:32];
        o[12] = ctr[31:0];
        o[13] = ctr[63:32];
        o[14] = nlo[63:32];
        o[15] = nhi;
        return o;
    endfunction

    assign core_init = make_init(r_key0, r_key1, r_key2, r_key3, r_nonce_lo, r_nonce_hi,
                                 r_ctr);
    assign ff_init   = make_init(r_key0, r_key1, r_key2, r_key3, r_nonce_lo, r_nonce_hi,
                                 r_blk);

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_init  (core_init),
        .o_busy  (core_busy),
        .o_words (core_words)
    );

    // feed-forward add happens here, one word per byte read
    assign ks_idx  = r_pos[5:2];
    assign ks_word = core_words[ks_idx] + ff_init[ks_idx];
    assign ks_byte = ks_word[8*r_pos[1:0] +: 8];

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_mvalid || m_axis_tready);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign acc_cfg       = i_cfg_valid && o_cfg_ready;
    assign core_start    = acc_in && r_pos[6];

    always_comb begin
        n_state     = r_state;
        n_key0      = r_key0;
        n_key1      = r_key1;
        n_key2      = r_key2;
        n_key3      = r_key3;
        n_nonce_lo  = r_nonce_lo;
        n_nonce_hi  = r_nonce_hi;
        n_start     = r_start;
        n_ctr       = r_ctr;
        n_blk       = r_blk;
        n_pos       = r_pos;
        n_hold_data = r_hold_data;
        n_hold_last = r_hold_last;
        n_mdata     = r_mdata;
        n_mlast     = r_mlast;
        n_mvalid    = r_mvalid;
        cfg_hit     = 1'b0;

        if (r_mvalid && m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (acc_in) begin
                    if (r_pos[6]) begin
                        // keystream used up: park the word, make the next block
                        n_hold_data = s_axis_tdata;
                        n_hold_last = s_axis_tlast;
                        n_blk       = r_ctr;
                        n_ctr       = r_ctr + 64'd1;
                        n_pos       = '0;
                        n_state     = ST_GEN;
                    end else begin
                        n_mdata  = s_axis_tdata ^ ks_byte;
                        n_mlast  = s_axis_tlast;
                        n_mvalid = 1'b1;
                        n_pos    = r_pos + 1'b1;
                    end
                end
            end
            ST_GEN: begin
                if (!core_busy) begin
                    n_mdata  = r_hold_data ^ ks_byte;
                    n_mlast  = r_hold_last;
                    n_mvalid = 1'b1;
                    n_pos    = r_pos + 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (acc_cfg) begin
            cfg_hit = 1'b1;
            case (i_cfg_index)
                CFG_KEY0:      n_key0     = i_cfg_data;
                CFG_KEY1:      n_key1     = i_cfg_data;
                CFG_KEY2:      n_key2     = i_cfg_data;
                CFG_KEY3:      n_key3     = i_cfg_data;
                CFG_NONCE_LO:  n_nonce_lo = i_cfg_data;
                CFG_NONCE_HI:  n_nonce_hi = i_cfg_data[31:0];
                CFG_START_CTR: n_start    = i_cfg_data;
                default:       cfg_hit    = 1'b0;
            endcase
        end

        // restart: reload both counter words and empty the keystream
        if (cfg_hit) begin
            n_ctr = {n_nonce_lo[31:0] + n_start[63:32], n_start[31:0]};
            n_pos = CC20_POS_W'(CC20_BLOCK_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_key0     <= '0;
            r_key1     <= '0;
            r_key2     <= '0;
            r_key3     <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_start    <= '0;
            r_ctr      <= '0;
            r_pos      <= CC20_POS_W'(CC20_BLOCK_BYTES);
            r_mvalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_key0     <= n_key0;
            r_key1     <= n_key1;
            r_key2     <= n_key2;
            r_key3     <= n_key3;
            r_nonce_lo <= n_nonce_lo;
            r_nonce_hi <= n_nonce_hi;
            r_start    <= n_start;
            r_ctr      <= n_ctr;
            r_pos      <= n_pos;
            r_mvalid   <= n_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk       <= n_blk;
        r_hold_data <= n_hold_data;
        r_hold_last <= n_hold_last;
        r_mdata     <= n_mdata;
        r_mlast     <= n_mlast;
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;

    `CC20_ASSERT_NEXT(a_block_starts, core_start, core_busy,
        "block generation did not start after an empty-keystream word")
    `CC20_ASSERT_IMP(a_out_free_in_gen, r_state == ST_GEN, !r_mvalid,
        "output register busy while a block is generated")
    `CC20_ASSERT_IMP(a_busy_only_in_gen, core_busy, r_state == ST_GEN,
        "core running outside block generation")
    `CC20_ASSERT_IMP(a_pos_range, 1'b1, r_pos <= CC20_POS_W'(CC20_BLOCK_BYTES),
        "keystream position past end of block")

endmodule

/* rtl/cc20_core.sv */
module cc20_core
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = CC20_DOUBLE_ROUNDS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_words i_init,
    output logic   o_busy,
    output t_words o_words
);

    localparam int STEPS  = 16 * DOUBLE_ROUNDS;
    localparam int STEP_W = $clog2(STEPS);

    typedef enum logic [1:0] {
        CS_IDLE = 2'b01,
        CS_RUN  = 2'b10
    } t_cstate;

    t_cstate           r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_words            r_w, n_w;
    t_words            half_w;
    t_words            step_w;
    logic [2:0]        qr_idx;
    logic [1:0]        perm_k;

    // half of a quarter round on the fixed column (0, 4, 8, 12)
    function automatic t_words half_qr(t_words w, logic second);
        t_words      o;
        logic [31:0] a, b, c, d;
        o = w;
        a = w[0] + w[4];
        d = w[12] ^ a;
        d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
        c = w[8] + d;
        b = w[4] ^ c;
        b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
        o[0]  = a;
        o[4]  = b;
        o[8]  = c;
        o[12] = d;
        return o;
    endfunction

    // row r rotates left by (1 + k*r) mod 4: k=0 next column, k=1 diagonalize,
    // k=3 undo the diagonal layout
    function automatic t_words permute(t_words w, logic [1:0] k);
        t_words     o;
        logic [1:0] sh;
        o = w;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sh = 2'(c) + 2'd1 + 2'(int'(k) * r);
                o[4*r+c] = w[4*r+int'(sh)];
            end
        end
        return o;
    endfunction

    assign qr_idx = r_step[3:1];
    assign half_w = half_qr(r_w, r_step[0]);

    always_comb begin
        case (qr_idx)
            3'd3:    perm_k = 2'd1;
            3'd7:    perm_k = 2'd3;
            default: perm_k = 2'd0;
        endcase
        step_w = r_step[0] ? permute(half_w, perm_k) : half_w;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_w     = r_w;
        case (r_state)
            CS_IDLE: begin
                if (i_start) begin
                    n_w     = i_init;
                    n_step  = '0;
                    n_state = CS_RUN;
                end
            end
            CS_RUN: begin
                n_w    = step_w;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    assign o_busy  = (r_state == CS_RUN);
    assign o_words = r_w;

endmodule
